[src/ipcidr_pkg.sv]
// Package for the IPv4 CIDR text parser: status and phase codes, the record
// that travels from the front to the back, and shared constants.
// No dependencies.
`default_nettype none

package ipcidr_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  localparam int unsigned ADDR_MAX_CHARS   = 15;
  localparam int unsigned PREFIX_MAX_CHARS = 3;
  localparam int unsigned NUM_OCTETS       = 4;
  localparam int unsigned MAX_PREFIX       = 32;

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FORM   = 3'd1,
    ST_LONG   = 3'd2,
    ST_ADDR   = 3'd3,
    ST_NOTINT = 3'd4,
    ST_RANGE  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_SPACE  = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] address;
    logic [5:0]  mask_len;
  } record_t;

endpackage

`default_nettype wire

[src/ipcidr_front.sv]
// Front part of the CIDR parser: takes one character per cycle while accept_i
// is high, runs the address and prefix parsers and classifies the text at its
// last character. Depends on ipcidr_pkg.
`default_nettype none

module ipcidr_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept_i,
  input  wire logic [7:0]        text_byte_i,
  input  wire logic              last_byte_i,
  output ipcidr_pkg::record_t    rec_o,
  output logic                   rec_push_o
);
  import ipcidr_pkg::*;

  logic [1:0]  slash_cnt_r, slash_cnt_nxt;
  logic        slash_start_r, slash_start_nxt;
  logic [4:0]  addr_chars_r, addr_chars_nxt;
  logic [2:0]  pfx_chars_r, pfx_chars_nxt;
  logic [7:0]  octet_r, octet_nxt;
  logic        octet_dig_r, octet_dig_nxt;
  logic [2:0]  octets_r, octets_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic        addr_bad_r, addr_bad_nxt;
  phase_t      phase_r, phase_nxt;
  logic        pfx_neg_r, pfx_neg_nxt;
  logic [9:0]  pfx_val_r, pfx_val_nxt;
  logic        pfx_bad_r, pfx_bad_nxt;

  logic        is_digit;
  logic        is_space;
  logic [3:0]  digit;
  logic [11:0] octet_acc;
  logic [9:0]  pfx_acc;

  assign is_digit  = text_byte_i inside {[CHAR_ZERO:CHAR_NINE]};
  assign is_space  = text_byte_i inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
  assign digit     = text_byte_i[3:0];
  assign octet_acc = {1'b0, octet_r, 3'b000} + {3'b000, octet_r, 1'b0} + {8'd0, digit};
  assign pfx_acc   = {pfx_val_r[6:0], 3'b000} + {pfx_val_r[8:0], 1'b0} + {6'd0, digit};

  // Next state of all parser registers for the current character.
  always_comb begin
    slash_cnt_nxt   = slash_cnt_r;
    slash_start_nxt = slash_start_r;
    addr_chars_nxt  = addr_chars_r;
    pfx_chars_nxt   = pfx_chars_r;
    octet_nxt       = octet_r;
    octet_dig_nxt   = octet_dig_r;
    octets_nxt      = octets_r;
    addr_nxt        = addr_r;
    addr_bad_nxt    = addr_bad_r;
    phase_nxt       = phase_r;
    pfx_neg_nxt     = pfx_neg_r;
    pfx_val_nxt     = pfx_val_r;
    pfx_bad_nxt     = pfx_bad_r;

    if (text_byte_i == CHAR_SLASH) begin
      if (slash_cnt_r == 2'd0) begin
        if (addr_chars_r == 5'd0) begin
          slash_start_nxt = 1'b1;
        end
        if (!addr_bad_r) begin
          addr_nxt = {addr_r[23:0], octet_r};
        end
      end
      if (slash_cnt_r < 2'd2) begin
        slash_cnt_nxt = slash_cnt_r + 2'd1;
      end
    end else if (slash_cnt_r == 2'd0) begin
      if (addr_chars_r < 5'd16) begin
        addr_chars_nxt = addr_chars_r + 5'd1;
      end
      if (!addr_bad_r) begin
        if (is_digit) begin
          if (octet_dig_r && (octet_r == 8'd0)) begin
            addr_bad_nxt = 1'b1;
          end else if (octet_acc > 12'd255) begin
            addr_bad_nxt = 1'b1;
          end else begin
            octet_nxt = octet_acc[7:0];
            if (!octet_dig_r) begin
              if (octets_r >= 3'(NUM_OCTETS)) begin
                addr_bad_nxt = 1'b1;
              end else begin
                octets_nxt    = octets_r + 3'd1;
                octet_dig_nxt = 1'b1;
              end
            end
          end
        end else if ((text_byte_i == CHAR_DOT) && octet_dig_r) begin
          if (octets_r == 3'(NUM_OCTETS)) begin
            addr_bad_nxt = 1'b1;
          end else begin
            addr_nxt      = {addr_r[23:0], octet_r};
            octet_nxt     = 8'd0;
            octet_dig_nxt = 1'b0;
          end
        end else begin
          addr_bad_nxt = 1'b1;
        end
      end
    end else begin
      if (pfx_chars_r < 3'd4) begin
        pfx_chars_nxt = pfx_chars_r + 3'd1;
      end
      if ((slash_cnt_r == 2'd1) && !pfx_bad_r) begin
        if (is_digit) begin
          phase_nxt   = PH_DIGITS;
          pfx_val_nxt = pfx_acc;
        end else if ((phase_r == PH_SPACE) && is_space) begin
          phase_nxt = PH_SPACE;
        end else if ((phase_r == PH_SPACE) &&
                     ((text_byte_i == CHAR_PLUS) || (text_byte_i == CHAR_MINUS))) begin
          phase_nxt   = PH_SIGN;
          pfx_neg_nxt = (text_byte_i == CHAR_MINUS);
        end else begin
          pfx_bad_nxt = 1'b1;
        end
      end
    end
  end

  // Classification of the text as it stands after the current character.
  always_comb begin
    rec_o.status   = ST_OK;
    rec_o.address  = 32'd0;
    rec_o.mask_len = 6'd0;
    if ((slash_cnt_nxt != 2'd1) || slash_start_nxt || (pfx_chars_nxt == 3'd0)) begin
      rec_o.status = ST_FORM;
    end else if ((addr_chars_nxt > 5'(ADDR_MAX_CHARS)) ||
                 (pfx_chars_nxt > 3'(PREFIX_MAX_CHARS))) begin
      rec_o.status = ST_LONG;
    end else if (addr_bad_nxt || (octets_nxt != 3'(NUM_OCTETS))) begin
      rec_o.status = ST_ADDR;
    end else if (pfx_bad_nxt || (phase_nxt != PH_DIGITS)) begin
      rec_o.status = ST_NOTINT;
    end else if ((pfx_neg_nxt && (pfx_val_nxt != 10'd0)) ||
                 (pfx_val_nxt > 10'(MAX_PREFIX))) begin
      rec_o.status = ST_RANGE;
    end else begin
      rec_o.address  = addr_nxt;
      rec_o.mask_len = pfx_val_nxt[5:0];
    end
  end

  assign rec_push_o = accept_i && last_byte_i;

  always_ff @(posedge clk) begin
    if (!rst_n || (accept_i && last_byte_i)) begin
      slash_cnt_r   <= 2'd0;
      slash_start_r <= 1'b0;
      addr_chars_r  <= 5'd0;
      pfx_chars_r   <= 3'd0;
      octet_r       <= 8'd0;
      octet_dig_r   <= 1'b0;
      octets_r      <= 3'd0;
      addr_r        <= 32'd0;
      addr_bad_r    <= 1'b0;
      phase_r       <= PH_SPACE;
      pfx_neg_r     <= 1'b0;
      pfx_val_r     <= 10'd0;
      pfx_bad_r     <= 1'b0;
    end else if (accept_i) begin
      slash_cnt_r   <= slash_cnt_nxt;
      slash_start_r <= slash_start_nxt;
      addr_chars_r  <= addr_chars_nxt;
      pfx_chars_r   <= pfx_chars_nxt;
      octet_r       <= octet_nxt;
      octet_dig_r   <= octet_dig_nxt;
      octets_r      <= octets_nxt;
      addr_r        <= addr_nxt;
      addr_bad_r    <= addr_bad_nxt;
      phase_r       <= phase_nxt;
      pfx_neg_r     <= pfx_neg_nxt;
      pfx_val_r     <= pfx_val_nxt;
      pfx_bad_r     <= pfx_bad_nxt;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept_i && last_byte_i) |=> (slash_cnt_r == 2'd0) && (addr_chars_r == 5'd0) &&
                                  (pfx_chars_r == 3'd0) && !addr_bad_r && !pfx_bad_r)
    else $error("parser state not cleared after the last character");
  a_octet_count: assert property (@(posedge clk) disable iff (!rst_n)
    (octets_r <= 3'(NUM_OCTETS)) && (slash_cnt_r != 2'd3))
    else $error("octet or slash count out of range");
`endif

endmodule

`default_nettype wire

[src/ipcidr_queue.sv]
// Short register queue that decouples the CIDR parser front from its back.
// Depends on ipcidr_pkg for the record type.
`default_nettype none

module ipcidr_queue #(
  parameter int unsigned DEPTH = ipcidr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push_i,
  input  wire ipcidr_pkg::record_t  data_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output ipcidr_pkg::record_t       data_o,
  output logic                      empty_o
);
  import ipcidr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  record_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (count_r == CNT_W'(DEPTH));
  assign empty_o = (count_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond its depth");
  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue lost a pushed record");
`endif

endmodule

`default_nettype wire

[src/ipcidr_back.sv]
// Back part of the CIDR parser: masks the address with the prefix and holds
// the result in the output register until it is taken.
// Depends on ipcidr_pkg.
`default_nettype none

module ipcidr_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_empty_i,
  input  wire ipcidr_pkg::record_t  q_data_i,
  output logic                      q_pop_o,
  output logic [2:0]                status_o,
  output logic [31:0]               network_o,
  output logic [5:0]                mask_len_o,
  output logic                      empty_o,
  input  wire logic                 pop_i
);
  import ipcidr_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  status_r;
  logic [31:0] network_r, network_nxt;
  logic [5:0]  plen_r;

  // A prefix of 32 shifts the ones out entirely, so the mask becomes all ones.
  assign network_nxt = q_data_i.address & ~(32'hFFFF_FFFF >> q_data_i.mask_len);
  assign q_pop_o     = !q_empty_i && (!out_valid_r || pop_i);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop_o) begin
      out_valid_nxt = 1'b1;
    end else if (pop_i) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop_o) begin
      status_r  <= q_data_i.status;
      network_r <= network_nxt;
      plen_r    <= q_data_i.mask_len;
    end
  end

  assign empty_o    = !out_valid_r;
  assign status_o   = status_r;
  assign network_o  = network_r;
  assign mask_len_o = plen_r;

`ifndef SYNTHESIS
  a_take_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_empty_i && !out_valid_r) |=> out_valid_r)
    else $error("waiting record not moved into a free output register");
`endif

endmodule

`default_nettype wire

[src/ipv4_cidr_text_parser.sv]
// IPv4 CIDR text parser, top level. Accepts one character per cycle while the
// queue has room. The result for a text passes from the front through the
// queue into the output register. Throughput: one character per cycle while
// the queue has room, as the front updates its accumulators for each character.
// Reset: synchronous active-low rst_n clears the parser state and empties the
// queue and the output register; no clearing pass is needed.
`default_nettype none

module ipv4_cidr_text_parser #(
  parameter int unsigned QUEUE_DEPTH = ipcidr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        in_last_byte,
  input  wire logic        push,
  output logic             full,
  output logic [2:0]       out_status,
  output logic [31:0]      out_network,
  output logic [5:0]       out_mask_len,
  output logic             empty,
  input  wire logic        pop
);
  import ipcidr_pkg::*;

  // The front parses every character in the cycle of its transfer. Only the
  // last character of a text produces a record, which goes into the queue.
  // The front is held back only when the queue has no room, so characters
  // keep flowing while a finished result waits at the output.
  record_t front_rec;
  logic    front_push;
  logic    in_accept;

  // The queue parts the front from the back, so that a stalled reader of the
  // results holds up the character stream only once the queue has filled.
  record_t q_data;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;

  assign full      = q_full;
  assign in_accept = push && !q_full;

  ipcidr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept_i    (in_accept),
    .text_byte_i (in_text_byte),
    .last_byte_i (in_last_byte),
    .rec_o       (front_rec),
    .rec_push_o  (front_push)
  );

  ipcidr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (front_push),
    .data_i  (front_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_data),
    .empty_o (q_empty)
  );

  // The back applies the prefix mask and keeps the result in an output
  // register; a new record moves in during the same cycle as the transfer
  // of the previous result.
  ipcidr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty_i  (q_empty),
    .q_data_i   (q_data),
    .q_pop_o    (q_pop),
    .status_o   (out_status),
    .network_o  (out_network),
    .mask_len_o (out_mask_len),
    .empty_o    (empty),
    .pop_i      (pop)
  );

endmodule

`default_nettype wire

[dv/ipv4_cidr_text_parser_tb.sv]
// Testbench for ipv4_cidr_text_parser: feeds CIDR texts one character per transfer
// and checks each status, network and prefix length against an in-bench parser.
// Depends on ipcidr_pkg for the status and phase codes and the character constants.
module ipv4_cidr_text_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ipcidr_pkg::*;

  // Roughly how many characters the run sends, directed texts included.
  localparam int unsigned ITEM_TARGET = 1550;
  // The watchdog ends the run after this many cycles without any transfer. The
  // longest legal quiet spell is one sender gap plus one receiver stall, and this
  // limit leaves a wide margin above it.
  localparam int unsigned STALL_LIMIT = 2000;
  // The result follows the last character through the queue and the output
  // register. The extra tail lets a stray result show up before the verdict.
  localparam int unsigned TAIL_CYCLES = 8;

  // One character on its way to the block. The gap is the number of idle cycles
  // before it is offered. A character marked hold is not offered until every
  // result that is owed has been taken.
  typedef struct {
    logic [7:0]  ch;
    logic        last;
    int unsigned gap;
    bit          hold;
  } char_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] network;
    logic [5:0]  plen;
  } cidr_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic [7:0]  in_text_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  out_status;
  logic [31:0] out_network;
  logic [5:0]  out_mask_len;
  logic        empty;
  logic        pop = 1'b0;

  char_item_t   char_queue[$];
  cidr_result_t due_results[$];
  logic [7:0]   text_buf[$];
  int unsigned  fail_count = 0;
  int unsigned  tx_calm_left = 0;
  int unsigned  rx_calm_left = 0;
  int unsigned  rx_stall = 0;
  string        symbols = "0123456789./+- ";

  // Parser state of the in-bench copy. It mirrors the block's counters,
  // including their saturation and wrap points.
  logic [1:0]  slash_cnt;
  logic        slash_first;
  logic [4:0]  addr_len;
  logic [2:0]  pfx_len;
  logic [7:0]  octet;
  logic        octet_digit;
  logic [2:0]  octet_cnt;
  logic [31:0] addr_acc;
  logic        addr_bad;
  phase_t      pfx_phase;
  logic        pfx_neg;
  logic [9:0]  pfx_acc;
  logic        pfx_bad;

  ipv4_cidr_text_parser i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_text_byte (in_text_byte),
    .in_last_byte (in_last_byte),
    .push         (push),
    .full         (full),
    .out_status   (out_status),
    .out_network  (out_network),
    .out_mask_len (out_mask_len),
    .empty        (empty),
    .pop          (pop)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_parser();
    slash_cnt   = '0;
    slash_first = 1'b0;
    addr_len    = '0;
    pfx_len     = '0;
    octet       = '0;
    octet_digit = 1'b0;
    octet_cnt   = '0;
    addr_acc    = '0;
    addr_bad    = 1'b0;
    pfx_phase   = PH_SPACE;
    pfx_neg     = 1'b0;
    pfx_acc     = '0;
    pfx_bad     = 1'b0;
  endfunction

  // Advances the parser by one accepted character. Returns 1 when the character
  // ends a text, with the result the block owes for that text in res.
  function automatic bit parse_char(input logic [7:0] ch, input logic last,
                                    output cidr_result_t res);
    logic [11:0] octet_next;
    logic [13:0] pfx_next;
    logic        is_num;
    res    = '{ST_OK, 32'd0, 6'd0};
    is_num = ch >= CHAR_ZERO && ch <= CHAR_NINE;
    if (ch == CHAR_SLASH) begin
      // Only the first slash closes the address; later ones merely count.
      if (slash_cnt == 2'd0) begin
        if (addr_len == 5'd0) slash_first = 1'b1;
        if (!addr_bad) addr_acc = {addr_acc[23:0], octet};
      end
      if (slash_cnt != 2'd2) slash_cnt = slash_cnt + 2'd1;
    end else if (slash_cnt == 2'd0) begin
      if (addr_len != 5'd16) addr_len = addr_len + 5'd1;
      if (!addr_bad) begin
        if (is_num) begin
          octet_next = octet * 12'd10 + (ch - CHAR_ZERO);
          if (octet_digit && octet == 8'd0) begin
            // A digit after a leading zero.
            addr_bad = 1'b1;
          end else if (octet_next > 12'd255) begin
            addr_bad = 1'b1;
          end else begin
            octet = octet_next[7:0];
            if (!octet_digit) begin
              if (octet_cnt >= NUM_OCTETS) begin
                addr_bad = 1'b1;
              end else begin
                octet_cnt   = octet_cnt + 3'd1;
                octet_digit = 1'b1;
              end
            end
          end
        end else if (ch == CHAR_DOT && octet_digit) begin
          if (octet_cnt == NUM_OCTETS) begin
            addr_bad = 1'b1;
          end else begin
            addr_acc    = {addr_acc[23:0], octet};
            octet       = '0;
            octet_digit = 1'b0;
          end
        end else begin
          addr_bad = 1'b1;
        end
      end
    end else begin
      if (pfx_len != 3'd4) pfx_len = pfx_len + 3'd1;
      // Behind a second slash the characters count toward the length only.
      if (slash_cnt == 2'd1 && !pfx_bad) begin
        if (is_num) begin
          pfx_phase = PH_DIGITS;
          pfx_next  = pfx_acc * 14'd10 + (ch - CHAR_ZERO);
          pfx_acc   = pfx_next[9:0];
        end else if (pfx_phase == PH_SPACE &&
                     (ch == CHAR_SPACE || (ch >= CHAR_TAB && ch <= CHAR_CR))) begin
          // Leading whitespace is skipped.
        end else if (pfx_phase == PH_SPACE && (ch == CHAR_PLUS || ch == CHAR_MINUS)) begin
          pfx_phase = PH_SIGN;
          pfx_neg   = ch == CHAR_MINUS;
        end else begin
          pfx_bad = 1'b1;
        end
      end
    end

    if (!last) return 1'b0;

    if (slash_cnt != 2'd1 || slash_first || pfx_len == 3'd0) begin
      res.status = ST_FORM;
    end else if (addr_len > ADDR_MAX_CHARS || pfx_len > PREFIX_MAX_CHARS) begin
      res.status = ST_LONG;
    end else if (addr_bad || octet_cnt != NUM_OCTETS) begin
      res.status = ST_ADDR;
    end else if (pfx_bad || pfx_phase != PH_DIGITS) begin
      res.status = ST_NOTINT;
    end else if ((pfx_neg && pfx_acc != '0) || pfx_acc > MAX_PREFIX) begin
      res.status = ST_RANGE;
    end else begin
      // A prefix of zero would need a shift by the full width, so it is kept apart.
      res.plen    = pfx_acc[5:0];
      res.network = (pfx_acc == '0) ? 32'd0
                                    : addr_acc & (32'hFFFF_FFFF << (MAX_PREFIX - pfx_acc));
    end
    clear_parser();
    return 1'b1;
  endfunction

  // Idle spells: mostly none, now and then a few cycles, rarely a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Half of the picks come from the characters that the parser cares about,
  // the rest from the whole legal byte range so that every bit toggles.
  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 1) == 0) return symbols[$urandom_range(0, symbols.len() - 1)];
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  // Moves the text being built into the character queue, the last character
  // marked, and gives each character its idle gap. Some texts go back to back.
  task automatic end_text(input bit hold_first);
    char_item_t it;
    bit         calm;
    calm = tx_calm_left != 0;
    if (calm) tx_calm_left--;
    else if ($urandom_range(0, 9) == 0) tx_calm_left = $urandom_range(5, 15);
    foreach (text_buf[i]) begin
      it.ch   = text_buf[i];
      it.last = i == text_buf.size() - 1;
      it.gap  = calm ? 0 : pick_gap();
      it.hold = hold_first && i == 0;
      char_queue.push_back(it);
    end
    text_buf.delete();
  endtask

  // Most random texts are well-formed CIDR strings with random content, so that
  // the parser gets through to the prefix checks; some of them are then
  // damaged, and the rest is noise.
  task automatic put_random_text();
    int unsigned oct[4];
    int unsigned pfx_val;
    int unsigned n_mut;
    int unsigned pos;
    if ($urandom_range(0, 99) < 85) begin
      foreach (oct[n]) begin
        oct[n] = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 255 : 0)
                                             : $urandom_range(0, 255);
      end
      put_str($sformatf("%0d.%0d.%0d.%0d/", oct[0], oct[1], oct[2], oct[3]));
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 2)) text_buf.push_back(($urandom_range(0, 1) == 0)
            ? CHAR_SPACE : 8'($urandom_range(CHAR_TAB, CHAR_CR)));
      end
      if ($urandom_range(0, 3) == 0) begin
        text_buf.push_back($urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS);
      end
      if ($urandom_range(0, 9) == 0) text_buf.push_back(CHAR_ZERO);
      pfx_val = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 32) : $urandom_range(33, 999);
      put_str($sformatf("%0d", pfx_val));
      n_mut = $urandom_range(0, 99);
      n_mut = (n_mut < 65) ? 0 : (n_mut < 90) ? 1 : $urandom_range(2, 6);
      repeat (n_mut) begin
        pos = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 2))
          0: text_buf[pos] = pick_char();
          1: if (text_buf.size() > 1) text_buf.delete(pos);
          default: text_buf.insert(pos, pick_char());
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 24)) text_buf.push_back(pick_char());
    end
  endtask

  // Sender. A new character is offered only when the slot is free or its
  // current character transfers at this edge, so push is assigned once per edge.
  always @(posedge clk) begin : drive_chars
    char_item_t nxt;
    if (!rst_n) begin
      push <= 1'b0;
    end else if (!push || !full) begin
      if (char_queue.size() == 0) begin
        push <= 1'b0;
      end else if (char_queue[0].gap != 0) begin
        char_queue[0].gap = char_queue[0].gap - 1;
        push <= 1'b0;
      end else if (char_queue[0].hold && (push || !empty || due_results.size() != 0)) begin
        // Hold back until the block is quiet and every owed result has been
        // taken. With push and empty both low here, no transfer at this edge
        // can change the queue of owed results.
        push <= 1'b0;
      end else begin
        nxt = char_queue.pop_front();
        push         <= 1'b1;
        in_text_byte <= nxt.ch;
        in_last_byte <= nxt.last;
      end
    end
  end

  // Receiver. After each transfer pop may drop for a random stall, and now and
  // then it stays high through a run of results.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (pop && !empty) begin
      if (rx_calm_left != 0) begin
        rx_calm_left--;
        rx_stall = 0;
      end else begin
        if ($urandom_range(0, 19) == 0) rx_calm_left = $urandom_range(5, 30);
        rx_stall = pick_gap();
      end
      pop <= rx_stall == 0;
    end else if (rx_stall != 0) begin
      rx_stall--;
      pop <= rx_stall == 0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Scoreboard. The result transfer is checked before the character transfer
  // of the same edge is predicted, so that a result which comes too early can
  // never be matched against the expectation it would have fulfilled.
  always @(posedge clk) begin
    cidr_result_t want;
    if (!rst_n) begin
      clear_parser();
    end else begin
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("ERROR: result with none owed: status %0d network %h prefix %0d",
                     out_status, out_network, out_mask_len);
          end
        end else begin
          want = due_results.pop_front();
          if (out_status !== want.status || out_network !== want.network ||
              out_mask_len !== want.plen) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("ERROR: status %0d/%0d network %h/%h prefix %0d/%0d (expected/actual)",
                       want.status, out_status, want.network, out_network,
                       want.plen, out_mask_len);
            end
          end
        end
      end
      if (push && !full) begin
        if (parse_char(in_text_byte, in_last_byte, want)) due_results.push_back(want);
      end
    end
  end

  // Watchdog: any transfer on either side restarts the count.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : run
    bit    drain_done;
    string directed[] = '{
      "255.255.255.255/32", "0.0.0.0/0", "192.168.1.77/24", "10.1.2.3/-0", "1.2.3.4/+31",
      "/8", "/", "1.2.3.4", "1.2.3.4/", "1.2.3.4/8/", "1.2.3.4//8",
      "100.200.100.200/1", "1000.200.100.200/8", "1.2.3.4/0032",
      "01.2.3.4/8", "256.1.1.1/8", "1..2.3/8", "1.2.3.4./8", "1.2.3/8", "1.2.3.4.5/8",
      "1.2.3.a/8", "1.2.3.4/8x", "1.2.3.4/+", "1.2.3.4/+-1", "1.2.3.4/33", "1.2.3.4/-1",
      "1.2.3.4/999"
    };
    drain_done = 1'b0;

    // Directed texts: extreme addresses and prefixes, the signed zero, every
    // form error, both length limits, each way an address goes wrong, and the
    // integer and range errors of the prefix.
    foreach (directed[i]) begin
      put_str(directed[i]);
      end_text(1'b0);
    end
    // Whitespace ahead of a sign, and bytes with the top bit set in each half.
    put_str("9.8.7.6/");
    text_buf.push_back(CHAR_TAB);
    put_str("+9");
    end_text(1'b0);
    put_str("9.8.7.6/");
    text_buf.push_back(CHAR_CR);
    put_str("7");
    end_text(1'b0);
    put_str("1.2.3.4/");
    text_buf.push_back(8'hFF);
    end_text(1'b0);
    text_buf.push_back(8'h80);
    put_str(".2.3.4/8");
    end_text(1'b0);

    // The first random text and one in the middle wait for the block to drain.
    put_random_text();
    end_text(1'b1);
    while (char_queue.size() < ITEM_TARGET) begin
      put_random_text();
      if (!drain_done && char_queue.size() > ITEM_TARGET / 2) begin
        drain_done = 1'b1;
        end_text(1'b1);
      end else begin
        end_text(1'b0);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (char_queue.size() != 0 || push || due_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
